[src/utf8s_pkg.sv]
// Shared types, constants and state codes for the UTF-8 filter.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps
`default_nettype none
package utf8s_pkg;

	localparam int HOLD_DEPTH = 4;
	localparam int HOLD_IDX_W = $clog2(HOLD_DEPTH);
	localparam int HOLD_CNT_W = HOLD_IDX_W + 1;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] MASK_2      = 8'hE0;
	localparam logic [7:0] LEAD_2      = 8'hC0;
	localparam logic [7:0] MASK_3      = 8'hF0;
	localparam logic [7:0] LEAD_3      = 8'hE0;
	localparam logic [7:0] MASK_4      = 8'hF8;
	localparam logic [7:0] LEAD_4      = 8'hF0;
	localparam logic [7:0] MASK_CONT   = 8'hC0;
	localparam logic [7:0] CONT_TAG    = 8'h80;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_present;
		logic       text_done;
	} rsp_t;

	// Result of the shared byte classifier.
	typedef struct packed {
		logic [HOLD_CNT_W-1:0] seq_len;  // 0 when the byte cannot lead
		logic                  is_cont;  // 10xxxxxx
	} byte_class_t;

	// Events from the scan sequencer to the result queue.
	typedef struct packed {
		logic       push;
		logic [7:0] push_byte;
		logic       finish;
		logic       last;
	} scan_evt_t;

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_LEAD,
		SCAN_CONT,
		SCAN_EMIT
	} scan_state_t;

endpackage
`default_nettype wire

[src/utf8s_byte_class.sv]
// Shared byte classifier: sequence length of a lead byte and the continuation test.
// Depends on utf8s_pkg.
`timescale 1ns / 1ps
`default_nettype none
module utf8s_byte_class (
	input  logic [7:0]                 byte_in,
	output utf8s_pkg::byte_class_t     cls
);
	import utf8s_pkg::*;

	always_comb begin
		if (byte_in < ASCII_LIMIT) begin
			cls.seq_len = HOLD_CNT_W'(1);
		end else if ((byte_in & MASK_2) == LEAD_2) begin
			cls.seq_len = HOLD_CNT_W'(2);
		end else if ((byte_in & MASK_3) == LEAD_3) begin
			cls.seq_len = HOLD_CNT_W'(3);
		end else if ((byte_in & MASK_4) == LEAD_4) begin
			cls.seq_len = HOLD_CNT_W'(4);
		end else begin
			cls.seq_len = '0;
		end
		cls.is_cont = (byte_in & MASK_CONT) == CONT_TAG;
	end

endmodule
`default_nettype wire

[src/utf8s_scan.sv]
// Holding buffer and scan sequencer: classifies one held byte per cycle
// through the shared classifier and pushes kept bytes. Depends on utf8s_pkg, utf8s_byte_class.
`timescale 1ns / 1ps
`default_nettype none
module utf8s_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  utf8s_pkg::req_t      req,
	output logic                 busy,
	output utf8s_pkg::scan_evt_t evt
);
	import utf8s_pkg::*;

	scan_state_t           state_q, state_d;
	logic [7:0]            hold_q [HOLD_DEPTH];
	logic [HOLD_CNT_W-1:0] cnt_q, cnt_d;
	logic [HOLD_CNT_W-1:0] len_q, len_d;
	logic [HOLD_IDX_W-1:0] j_q, j_d;
	logic                  last_q;
	logic                  load;
	logic                  shift_en;
	logic [HOLD_CNT_W-1:0] shift_k;
	logic [7:0]            sel_byte;
	byte_class_t           cls;

	assign sel_byte = hold_q[j_q];

	utf8s_byte_class u_class (
		.byte_in (sel_byte),
		.cls     (cls)
	);

	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		len_d         = len_q;
		j_d           = j_q;
		load          = 1'b0;
		shift_en      = 1'b0;
		shift_k       = '0;
		evt.push      = 1'b0;
		evt.push_byte = sel_byte;
		evt.finish    = 1'b0;
		evt.last      = last_q;
		case (state_q)
			SCAN_IDLE: begin
				if (start) begin
					load    = 1'b1;
					cnt_d   = cnt_q + HOLD_CNT_W'(1);
					j_d     = '0;
					state_d = SCAN_LEAD;
				end
			end
			SCAN_LEAD: begin
				len_d = cls.seq_len;
				if (cnt_q == '0 || (cls.seq_len != '0 && cnt_q < cls.seq_len)) begin
					// nothing complete left: end the scan, flush on end of text
					evt.finish = 1'b1;
					if (last_q) begin
						cnt_d = '0;
						len_d = '0;
					end
					state_d = SCAN_IDLE;
				end else if (cls.seq_len == '0) begin
					shift_en = 1'b1;
					shift_k  = HOLD_CNT_W'(1);
					cnt_d    = cnt_q - HOLD_CNT_W'(1);
				end else if (cls.seq_len == HOLD_CNT_W'(1)) begin
					state_d = SCAN_EMIT;
				end else begin
					j_d     = HOLD_IDX_W'(1);
					state_d = SCAN_CONT;
				end
			end
			SCAN_CONT: begin
				if (!cls.is_cont) begin
					// drop only the lead and rescan
					shift_en = 1'b1;
					shift_k  = HOLD_CNT_W'(1);
					cnt_d    = cnt_q - HOLD_CNT_W'(1);
					j_d      = '0;
					state_d  = SCAN_LEAD;
				end else if ({1'b0, j_q} == len_q - HOLD_CNT_W'(1)) begin
					j_d     = '0;
					state_d = SCAN_EMIT;
				end else begin
					j_d = j_q + HOLD_IDX_W'(1);
				end
			end
			SCAN_EMIT: begin
				evt.push = 1'b1;
				if ({1'b0, j_q} == len_q - HOLD_CNT_W'(1)) begin
					shift_en = 1'b1;
					shift_k  = len_q;
					cnt_d    = cnt_q - len_q;
					j_d      = '0;
					state_d  = SCAN_LEAD;
				end else begin
					j_d = j_q + HOLD_IDX_W'(1);
				end
			end
			default: begin
				state_d = SCAN_IDLE;
			end
		endcase
	end

	assign busy = state_q != SCAN_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SCAN_IDLE;
			cnt_q   <= '0;
			len_q   <= '0;
			j_q     <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			len_q   <= len_d;
			j_q     <= j_d;
			if (load) begin
				last_q <= req.end_of_text;
			end
		end
	end

	// holding buffer: append at the fill count, advance the front past dropped or emitted bytes
	always_ff @(posedge clk) begin
		if (load) begin
			hold_q[cnt_q[HOLD_IDX_W-1:0]] <= req.in_byte;
		end else if (shift_en) begin
			for (int i = 0; i < HOLD_DEPTH; i++) begin
				if (HOLD_CNT_W'(i) + shift_k < HOLD_CNT_W'(HOLD_DEPTH)) begin
					hold_q[i] <= hold_q[HOLD_IDX_W'(HOLD_CNT_W'(i) + shift_k)];
				end
			end
		end
	end

endmodule
`default_nettype wire

[src/utf8_invalid_byte_stripper_core.sv]
// Top level of the UTF-8 filter: scan sequencer plus the result queue that
// tags the final result. Depends on utf8s_pkg, utf8s_scan.
`timescale 1ns / 1ps
`default_nettype none
//
// Channel   Direction  Handshake            Payload
// request   in         req_valid/req_stall  req : in_byte, end_of_text
// result    out        rsp_valid/rsp_stall  rsp : out_byte, byte_present, text_done
//
// A request is loaded, then scanned in steps of the shared byte classifier
// (one per lead test, continuation test and kept byte, at most nine for four
// held bytes, closing lead test included); its results then drain in order.
// Reset (arst_n low) empties the holding buffer and the result queue at once.
// req_stall stays high from the accept until the last result of that request
// is taken; a high rsp_stall holds the current result in place.
module utf8_invalid_byte_stripper_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  utf8s_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output utf8s_pkg::rsp_t rsp
);
	import utf8s_pkg::*;

	logic                  scan_busy;
	logic                  start;
	scan_evt_t             evt;
	logic [7:0]            q_byte_q    [HOLD_DEPTH];
	logic                  q_present_q [HOLD_DEPTH];
	logic [HOLD_CNT_W-1:0] q_cnt_q;
	logic [HOLD_IDX_W-1:0] rd_q;
	logic                  drain_q;
	logic                  last_q;
	logic                  pop;
	logic                  final_pop;
	logic                  marker;

	// accept only when the scan is idle and all results are delivered
	assign req_stall = scan_busy || drain_q;
	assign start     = req_valid && !req_stall;

	utf8s_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (scan_busy),
		.evt    (evt)
	);

	// bare end marker when the text ends with nothing kept in this request
	assign marker = evt.finish && evt.last && (q_cnt_q == '0);

	assign rsp_valid        = drain_q;
	assign rsp.out_byte     = q_byte_q[rd_q];
	assign rsp.byte_present = q_present_q[rd_q];
	assign final_pop        = ({1'b0, rd_q} + HOLD_CNT_W'(1)) == q_cnt_q;
	assign rsp.text_done    = last_q && final_pop;
	assign pop              = drain_q && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_cnt_q <= '0;
			rd_q    <= '0;
			drain_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			if (evt.push || marker) begin
				q_cnt_q <= q_cnt_q + HOLD_CNT_W'(1);
			end
			if (evt.finish) begin
				// start draining only when there is something to hand over
				drain_q <= (q_cnt_q != '0) || evt.last;
				last_q  <= evt.last;
			end
			if (pop) begin
				if (final_pop) begin
					// queue empty: rewind for the next request
					drain_q <= 1'b0;
					q_cnt_q <= '0;
					rd_q    <= '0;
				end else begin
					rd_q <= rd_q + HOLD_IDX_W'(1);
				end
			end
		end
	end

	// result queue storage: fill during the scan, drain afterwards
	always_ff @(posedge clk) begin
		if (evt.push) begin
			q_byte_q[q_cnt_q[HOLD_IDX_W-1:0]]    <= evt.push_byte;
			q_present_q[q_cnt_q[HOLD_IDX_W-1:0]] <= 1'b1;
		end else if (marker) begin
			q_byte_q[q_cnt_q[HOLD_IDX_W-1:0]]    <= 8'h00;
			q_present_q[q_cnt_q[HOLD_IDX_W-1:0]] <= 1'b0;
		end
	end

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for utf8_invalid_byte_stripper_core: a directed table
// and random texts of well-formed, broken and cut-off UTF-8, checked by a predictor.
// Depends on utf8s_pkg and the RTL in src.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import utf8s_pkg::*;

	// How the expected results of one request are found.
	typedef enum logic [1:0] {
		ROW_PREDICTED,   // work them out with the filter predictor
		ROW_NO_RESULT,   // typed in: the request yields nothing
		ROW_ONE_RESULT   // typed in: the request yields exactly rsp
	} row_mode_t;

	typedef struct packed {
		req_t      item;
		row_mode_t mode;
		rsp_t      rsp;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// Predictor state: bytes held while a sequence is incomplete; entry 0 is the lead.
	logic [7:0]  held_bytes [HOLD_DEPTH];
	int unsigned held_count;

	rsp_t      predicted [$];     // results of the request being predicted
	rsp_t      due_results [$];   // results still owed by the block, oldest first
	stim_row_t queued_rows [$];   // one entry per request on its way into the block
	int        mismatch_count;
	bit        idle_on;           // clear for stretches of full-rate traffic on both sides

	utf8_invalid_byte_stripper_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop: generous even with every request stalled out at worst case.
	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic rsp_t make_rsp(logic [7:0] b, logic present, logic done);
		rsp_t r;
		r.out_byte     = b;
		r.byte_present = present;
		r.text_done    = done;
		return r;
	endfunction

	function automatic stim_row_t dir_row(logic [7:0] b, logic eot, row_mode_t mode,
			rsp_t r);
		stim_row_t row;
		row.item.in_byte     = b;
		row.item.end_of_text = eot;
		row.mode             = mode;
		row.rsp              = r;
		return row;
	endfunction

	// Sequence length that a lead byte asks for; 0 when it cannot lead.
	function automatic int unsigned lead_length(logic [7:0] b);
		if (b < ASCII_LIMIT)
			return 1;
		if ((b & MASK_2) == LEAD_2)
			return 2;
		if ((b & MASK_3) == LEAD_3)
			return 3;
		if ((b & MASK_4) == LEAD_4)
			return 4;
		return 0;
	endfunction

	function automatic void drop_held(int unsigned k);
		for (int i = 0; i + k < held_count; i++)
			held_bytes[i] = held_bytes[i + k];
		held_count = held_count - k;
	endfunction

	// Push one byte into the held buffer, emit every complete well-formed sequence,
	// drop a lead whose continuation breaks and rescan what is left behind it.
	function automatic void filter_byte(req_t r);
		int unsigned len;
		bit          waiting;
		bit          cont_ok;
		rsp_t        last_rsp;
		predicted.delete();
		waiting = 1'b0;
		if (held_count < HOLD_DEPTH) begin
			held_bytes[held_count] = r.in_byte;
			held_count++;
		end
		while (held_count > 0 && !waiting) begin
			len = lead_length(held_bytes[0]);
			if (len == 0) begin
				drop_held(1);
			end else if (held_count < len) begin
				waiting = 1'b1;
			end else begin
				cont_ok = 1'b1;
				for (int j = 1; j < len; j++)
					if ((held_bytes[j] & MASK_CONT) != CONT_TAG)
						cont_ok = 1'b0;
				if (cont_ok) begin
					for (int j = 0; j < len; j++)
						if (predicted.size() < HOLD_DEPTH)
							predicted.push_back(make_rsp(held_bytes[j], 1'b1, 1'b0));
					drop_held(len);
				end else begin
					drop_held(1);
				end
			end
		end
		// End of text: discard a cut-off sequence whole and tag the final result.
		if (r.end_of_text) begin
			held_count = 0;
			if (predicted.size() == 0) begin
				predicted.push_back(make_rsp(8'h00, 1'b0, 1'b1));
			end else begin
				last_rsp = predicted[predicted.size() - 1];
				last_rsp.text_done = 1'b1;
				predicted[predicted.size() - 1] = last_rsp;
			end
		end
	endfunction

	// Gap length in cycles: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [7:0] lead_for(int unsigned len);
		case (len)
			2:       return LEAD_2 | 8'($urandom_range(0, 31));
			3:       return LEAD_3 | 8'($urandom_range(0, 15));
			default: return LEAD_4 | 8'($urandom_range(0, 7));
		endcase
	endfunction

	function automatic logic [7:0] cont_byte();
		return CONT_TAG | 8'($urandom_range(0, 63));
	endfunction

	// Present one request and hold it until the block takes it, then idle a while.
	// Valid stays high into the next request when no gap is drawn.
	task automatic send_request(input stim_row_t row);
		int unsigned g;
		queued_rows.push_back(row);
		req       <= row.item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		g = pick_gap();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Predict on each accepted request; compare each accepted result with the oldest
	// result still owed. Both sides see the values from before the edge.
	always @(posedge clk) begin : watch
		stim_row_t row;
		rsp_t      want;
		if (arst_n && req_valid && !req_stall) begin
			row = queued_rows.pop_front();
			filter_byte(req);
			case (row.mode)
				ROW_PREDICTED:  foreach (predicted[i]) due_results.push_back(predicted[i]);
				ROW_ONE_RESULT: due_results.push_back(row.rsp);
				default:        ;
			endcase
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, got byte %02h present %0b done %0b",
					$time, rsp.out_byte, rsp.byte_present, rsp.text_done);
				mismatch_count++;
			end else begin
				want = due_results.pop_front();
				if (rsp.out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %02h, got %02h",
						$time, want.out_byte, rsp.out_byte);
					mismatch_count++;
				end
				if (rsp.byte_present !== want.byte_present) begin
					$display("%0t: byte_present expected %0b, got %0b",
						$time, want.byte_present, rsp.byte_present);
					mismatch_count++;
				end
				if (rsp.text_done !== want.text_done) begin
					$display("%0t: text_done expected %0b, got %0b",
						$time, want.text_done, rsp.text_done);
					mismatch_count++;
				end
			end
		end
	end

	// Hold off the result side at random; idle_on off gives full-rate stretches.
	initial begin : result_stall
		int unsigned n;
		rsp_stall <= 1'b0;
		do
			@(posedge clk);
		while (!arst_n);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	end

	initial begin : stimulus
		stim_row_t   dir_rows [$];
		logic [7:0]  text [$];
		int unsigned rand_sent;
		int unsigned text_idx;
		int unsigned n_seq;
		int unsigned kind;
		int unsigned len;
		rsp_t        none;

		none           = make_rsp(8'h00, 1'b0, 1'b0);
		mismatch_count = 0;
		held_count     = 0;
		idle_on        = 1'b1;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;

		// Directed rows. The first four are plain enough to type in their results.
		// Lowest byte as a one-byte text: it comes back flagged done.
		dir_rows.push_back(dir_row(8'h00, 1'b1, ROW_ONE_RESULT, make_rsp(8'h00, 1'b1, 1'b1)));
		// Highest ASCII byte passes straight through.
		dir_rows.push_back(dir_row(8'h7F, 1'b0, ROW_ONE_RESULT, make_rsp(8'h7F, 1'b1, 1'b0)));
		// All ones cannot lead: drop it silently.
		dir_rows.push_back(dir_row(8'hFF, 1'b0, ROW_NO_RESULT, none));
		// Stray continuation as the last byte: nothing kept, so a bare end marker.
		dir_rows.push_back(dir_row(8'h80, 1'b1, ROW_ONE_RESULT, make_rsp(8'h00, 1'b0, 1'b1)));
		// Well-formed two, three and four byte sequences; the four-byte one ends a text.
		dir_rows.push_back(dir_row(8'hC3, 1'b0, ROW_PREDICTED, none));
		dir_rows.push_back(dir_row(8'hA9, 1'b0, ROW_PREDICTED, none));
		dir_rows.push_back(dir_row(8'hE2, 1'b0, ROW_PREDICTED, none));
		dir_rows.push_back(dir_row(8'h82, 1'b0, ROW_PREDICTED, none));
		dir_rows.push_back(dir_row(8'hAC, 1'b0, ROW_PREDICTED, none));
		dir_rows.push_back(dir_row(8'hF0, 1'b0, ROW_PREDICTED, none));
		dir_rows.push_back(dir_row(8'h9F, 1'b0, ROW_PREDICTED, none));
		dir_rows.push_back(dir_row(8'h98, 1'b0, ROW_PREDICTED, none));
		dir_rows.push_back(dir_row(8'h80, 1'b1, ROW_PREDICTED, none));
		// Broken two-byte lead: drop the lead, rescan keeps the ASCII byte.
		dir_rows.push_back(dir_row(8'hC3, 1'b0, ROW_PREDICTED, none));
		dir_rows.push_back(dir_row(8'h41, 1'b0, ROW_PREDICTED, none));
		// Broken three-byte lead: the held continuation is dropped on the rescan too.
		dir_rows.push_back(dir_row(8'hE2, 1'b0, ROW_PREDICTED, none));
		dir_rows.push_back(dir_row(8'h82, 1'b0, ROW_PREDICTED, none));
		dir_rows.push_back(dir_row(8'h41, 1'b0, ROW_PREDICTED, none));
		// Cut off at the end: the held ASCII byte goes with the lead, bare end marker.
		dir_rows.push_back(dir_row(8'hF0, 1'b0, ROW_PREDICTED, none));
		dir_rows.push_back(dir_row(8'h41, 1'b1, ROW_PREDICTED, none));
		// Full holding buffer that breaks on the last byte: three results, last one done.
		dir_rows.push_back(dir_row(8'hF0, 1'b0, ROW_PREDICTED, none));
		dir_rows.push_back(dir_row(8'h41, 1'b0, ROW_PREDICTED, none));
		dir_rows.push_back(dir_row(8'h42, 1'b0, ROW_PREDICTED, none));
		dir_rows.push_back(dir_row(8'h43, 1'b1, ROW_PREDICTED, none));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_request(dir_rows[i]);

		// Random texts: mostly well-formed sequences, with noise, broken and
		// cut-off sequences mixed in. Every fifth text runs with no idling.
		rand_sent = 0;
		text_idx  = 0;
		while (rand_sent < 180) begin
			idle_on = (text_idx % 5) != 4;
			text.delete();
			n_seq = $urandom_range(1, 6);
			repeat (n_seq) begin
				kind = $urandom_range(0, 99);
				if (kind < 30) begin
					text.push_back(8'($urandom_range(0, 127)));
				end else if (kind < 70) begin
					len = $urandom_range(2, 4);
					text.push_back(lead_for(len));
					repeat (len - 1) text.push_back(cont_byte());
				end else if (kind < 80) begin
					text.push_back(8'($urandom_range(0, 255)));
				end else if (kind < 90) begin
					// Break the sequence with an ASCII byte or a byte from C0 to FF, mostly another lead.
					len = $urandom_range(2, 4);
					text.push_back(lead_for(len));
					repeat ($urandom_range(0, len - 2)) text.push_back(cont_byte());
					if ($urandom_range(0, 1))
						text.push_back(8'($urandom_range(0, 127)));
					else
						text.push_back(MASK_CONT | 8'($urandom_range(0, 63)));
				end else begin
					text.push_back(cont_byte());
				end
			end
			// Sometimes leave a sequence unfinished at the end of the text.
			if ($urandom_range(0, 99) < 20) begin
				len = $urandom_range(2, 4);
				text.push_back(lead_for(len));
				repeat ($urandom_range(0, len - 2)) text.push_back(cont_byte());
			end
			foreach (text[i])
				send_request(dir_row(text[i], i == text.size() - 1, ROW_PREDICTED, none));
			rand_sent += text.size();
			text_idx++;
		end
		req_valid <= 1'b0;

		// Drain, then give the block a little longer to show any stray result.
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
`default_nettype wire

[sim.f]
src/utf8s_pkg.sv
src/utf8s_byte_class.sv
src/utf8s_scan.sv
src/utf8_invalid_byte_stripper_core.sv
tb/sv/tb_top.sv
